[hw/rtl/efps_pkg.sv]
// Shared widths, field types and the heap command bundle for the scheduler.
package efps_pkg;

  localparam int TIME_W = 48;  // free time / start time
  localparam int DUR_W  = 32;  // task duration
  localparam int IDX_W  = 10;  // reported worker index
  localparam int CNT_W  = 11;  // worker count register

  localparam logic [CNT_W-1:0] RESET_COUNT = 11'd1024;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [DUR_W-1:0]  dur_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Command from the port logic to the heap controller
  typedef struct packed {
    logic init;      // rebuild the heap: all workers free at time zero
    logic start;     // a task transaction is taken this cycle
    dur_t duration;  // duration of that task
  } heap_cmd_t;

endpackage

[hw/rtl/efps_task_if.sv]
// Task channel: one task duration per transaction.
interface efps_task_if;
  logic            valid;
  logic            ready;
  efps_pkg::dur_t  task_duration;

  modport source (output valid, output task_duration, input ready);
  modport sink   (input valid, input task_duration, output ready);
endinterface

[hw/rtl/efps_result_if.sv]
// Result channel: assigned worker and start time per transaction.
interface efps_result_if;
  logic            valid;
  logic            ready;
  efps_pkg::idx_t  worker_index;
  efps_pkg::time_t start_time;

  modport source (output valid, output worker_index, output start_time, input ready);
  modport sink   (input valid, input worker_index, input start_time, output ready);
endinterface

[hw/rtl/earliest_free_processor_scheduler.sv]
// Top level: earliest-free worker scheduler over a RAM-backed binary min-heap.
//
//   port      dir   transaction payload
//   tasks     in    task_duration (32b)
//   results   out   worker_index (10b), start_time (48b)
//   cfg_we    in    cfg_wdata (11b) = worker_count, written while cfg_we is high
//
// An item is accepted in ST_IDLE, then the sift-down visits one heap level per
// ST_SIFT step (one pair read and compare each); no task is taken until it ends.
// The result is loaded into the output register on accept.
// Reset and every worker_count write start a clearing pass over the pair RAM's
// (MAX_WORKERS + 1) / 2 rows (512 by default), during which tasks.ready is low.
// A stalled result holds the output register; the heap keeps sifting meanwhile.
module earliest_free_processor_scheduler #(
  parameter int MAX_WORKERS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  efps_pkg::cnt_t       cfg_wdata,
  efps_task_if.sink            tasks,
  efps_result_if.source        results
);

  localparam int WI    = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int PW    = $clog2(2*MAX_WORKERS+1);
  localparam int RST_N = (MAX_WORKERS < 1024) ? MAX_WORKERS : 1024;

  logic [PW-1:0]        worker_count;
  logic [31:0]          cfg_ext;
  logic [PW-1:0]        cfg_clamped;
  efps_pkg::heap_cmd_t  cmd;
  logic                 heap_idle;
  efps_pkg::time_t      root_time;
  logic [WI-1:0]        root_worker;
  logic                 take;

  // clamp the written worker count into 1..MAX_WORKERS
  always_comb begin
    cfg_ext = 32'(cfg_wdata);
    priority if (cfg_ext == 32'd0) begin
      cfg_clamped = PW'(1);
    end else if (cfg_ext > 32'(MAX_WORKERS)) begin
      cfg_clamped = PW'(MAX_WORKERS);
    end else begin
      cfg_clamped = PW'(cfg_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_count <= PW'(RST_N);
    end else if (cfg_we) begin
      worker_count <= cfg_clamped;
    end
  end

  // task handshake
  assign tasks.ready  = heap_idle && (!results.valid || results.ready);
  assign take         = tasks.valid && tasks.ready;
  assign cmd.init     = cfg_we;
  assign cmd.start    = take;
  assign cmd.duration = tasks.task_duration;

  efps_heap_ctrl #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_heap_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .worker_count (worker_count),
    .idle         (heap_idle),
    .root_time    (root_time),
    .root_worker  (root_worker)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (take) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      results.worker_index <= efps_pkg::IDX_W'(root_worker);
      results.start_time   <= root_time;
    end
  end

  // every accepted task yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> results.valid)
    else $error("accepted task produced no result");

  // a count write starts the clearing pass, which blocks tasks
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !tasks.ready)
    else $error("task ready right after a worker_count write");

  // the heap root names a worker in use whenever a task is taken
  a_root_in_range: assert property (@(posedge clk) disable iff (rst)
    take |-> (PW'(root_worker) < worker_count))
    else $error("heap root worker outside worker_count");

endmodule

[hw/rtl/efps_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module efps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then registered read (old data on same-cycle collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/efps_heap_ctrl.sv]
// Heap controller: root register, sibling-pair RAM, sift-down and clearing pass.
module efps_heap_ctrl #(
  parameter int MAX_WORKERS = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  efps_pkg::heap_cmd_t       cmd,
  input  logic [$clog2(2*MAX_WORKERS+1)-1:0] worker_count,
  output logic                      idle,
  output efps_pkg::time_t           root_time,
  output logic [(MAX_WORKERS > 1 ? $clog2(MAX_WORKERS) : 1)-1:0] root_worker
);

  localparam int WI   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int PW   = $clog2(2*MAX_WORKERS+1);
  localparam int ROWS = (MAX_WORKERS + 1) / 2;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int KW   = efps_pkg::TIME_W + WI;
  localparam int TW   = efps_pkg::TIME_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SIFT  = 2'd2;

  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  // Row r of the RAM holds heap entries 2r+1 (low half) and 2r+2 (high half);
  // an entry is the key {free time, worker}, so key order is the heap order.
  logic [1:0]     state;
  logic [RW-1:0]  clr_row;
  logic [KW-1:0]  root_key;
  logic [KW-1:0]  vkey;      // entry being sifted down
  logic [PW-1:0]  pos;       // hole position
  logic [2*KW-1:0] hold_row; // RAM row that contains pos

  logic           ram_we;
  logic [RW-1:0]  ram_waddr;
  logic [2*KW-1:0] ram_wdata;
  logic [RW-1:0]  ram_raddr;
  logic [2*KW-1:0] ram_rdata;

  logic [PW-1:0]  left;
  logic [PW-1:0]  right;
  logic [PW-1:0]  pos_m1;
  logic [PW-1:0]  clr_idx;
  logic           left_ok;
  logic           right_ok;
  logic [KW-1:0]  lkey;
  logic [KW-1:0]  rkey;
  logic           l_gt_r;
  logic           v_gt_l;
  logic           v_gt_r;
  logic           pick_right;
  logic           move;
  logic [KW-1:0]  ckey;
  logic [PW-1:0]  cpos;
  logic [KW-1:0]  place_key;
  logic [TW:0]    sum;
  efps_pkg::time_t adv_time;

  efps_ram #(
    .WIDTH (2*KW),
    .DEPTH (ROWS)
  ) u_heap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // saturating advance of the root's free time
  always_comb begin
    sum      = {1'b0, root_key[KW-1:WI]} + (TW+1)'(cmd.duration);
    adv_time = sum[TW] ? '1 : sum[TW-1:0];
  end

  // child selection for the current hole
  always_comb begin
    left       = {pos[PW-2:0], 1'b0} + PW'(1);
    right      = left + PW'(1);
    pos_m1     = pos - PW'(1);
    left_ok    = left < worker_count;
    right_ok   = right < worker_count;
    lkey       = ram_rdata[KW-1:0];
    rkey       = ram_rdata[2*KW-1:KW];
    l_gt_r     = lkey > rkey;
    v_gt_l     = vkey > lkey;
    v_gt_r     = vkey > rkey;
    pick_right = right_ok && l_gt_r;
    move       = left_ok && (pick_right ? v_gt_r : v_gt_l);
    ckey       = pick_right ? rkey : lkey;
    cpos       = pick_right ? right : left;
    place_key  = move ? ckey : vkey;
    clr_idx    = PW'({clr_row, 1'b0});
  end

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_row;
    ram_wdata = {{TW{1'b0}}, WI'(clr_idx + PW'(2)), {TW{1'b0}}, WI'(clr_idx + PW'(1))};
    ram_raddr = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_raddr = '0;
      end
      ST_SIFT: begin
        ram_we    = (pos != '0);
        ram_waddr = pos_m1[RW:1];
        ram_wdata = pos_m1[0] ? {place_key, hold_row[KW-1:0]}
                              : {hold_row[2*KW-1:KW], place_key};
        ram_raddr = cpos[RW-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      state    <= ST_CLEAR;
      clr_row  <= '0;
      root_key <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_row <= clr_row + RW'(1);
          if (clr_row == LAST_ROW) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd.start) begin
            vkey  <= {adv_time, root_key[WI-1:0]};
            pos   <= '0;
            state <= ST_SIFT;
          end
        end
        ST_SIFT: begin
          if (pos == '0) begin
            root_key <= place_key;
          end
          if (move) begin
            pos      <= cpos;
            hold_row <= ram_rdata;
          end else begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  assign idle        = (state == ST_IDLE);
  assign root_time   = root_key[KW-1:WI];
  assign root_worker = root_key[WI-1:0];

endmodule
